FILE: hdl/tarkf_pkg.sv
package tarkf_pkg;

  // widths and formats
  localparam int DEF_DATA_WIDTH = 32;
  localparam int FIELD_W        = 32;
  localparam int COEF_W         = 32;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_ADDR_W     = 6;
  localparam int REG_ADDR_LSB   = 3;
  localparam int COEF_FRAC      = 22;
  localparam int PERIOD_FRAC    = 16;
  localparam logic [COEF_W-1:0] INV_PERIOD_RST = 32'd8388608;

  // microprogram length for one axis
  localparam int PROG_LEN = 21;
  localparam int PC_W     = $clog2(PROG_LEN);

  // register map
  typedef enum logic [2:0] {
    REG_ACCEL_ROW,
    REG_RATE_ROW,
    REG_INPUT_COEF,
    REG_ACCEL_GAIN,
    REG_RATE_GAIN,
    REG_BIAS_GAIN,
    REG_INV_PERIOD
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] arow;
    logic [CFG_DATA_W-1:0] rrow;
    logic [CFG_DATA_W-1:0] incf;
    logic [CFG_DATA_W-1:0] kacc;
    logic [CFG_DATA_W-1:0] krate;
    logic [CFG_DATA_W-1:0] kbias;
    logic [COEF_W-1:0]     invp;
  } cfg_t;

  // micro-operations
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_SUB,
    OP_MUL,
    OP_MAC
  } op_t;

  typedef enum logic [3:0] {
    SRC_ZERO,
    SRC_ACC,
    SRC_A,
    SRC_R,
    SRC_B,
    SRC_P,
    SRC_U,
    SRC_M,
    SRC_R1,
    SRC_A1,
    SRC_DIFF,
    SRC_EA,
    SRC_ER
  } src_t;

  typedef enum logic [3:0] {
    C_A11,
    C_A13,
    C_A21,
    C_A23,
    C_B11,
    C_B21,
    C_KAA,
    C_KAR,
    C_KRA,
    C_KRR,
    C_KBA,
    C_KBR,
    C_INVP
  } coef_sel_t;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_R1,
    DST_A1,
    DST_DIFF,
    DST_EA,
    DST_ER,
    DST_A,
    DST_R,
    DST_B,
    DST_P
  } dst_t;

  typedef struct packed {
    op_t       op;
    src_t      src_a;
    src_t      src_b;
    coef_sel_t coef;
    dst_t      dst;
    logic      last;
  } uop_t;

  // datapath phase within one micro-operation
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_EXEC,
    PH_MUL_LO,
    PH_MUL_HI,
    PH_MUL_COMB,
    PH_MUL_ACC
  } phase_t;

  typedef struct packed {
    logic   capture;
    logic   publish;
    logic   axis;
    phase_t phase;
    uop_t   uop;
  } dp_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL_HI,
    ST_MUL_COMB,
    ST_MUL_ACC,
    ST_DONE
  } state_t;

  function automatic uop_t mk_uop(op_t op, src_t a, src_t b, coef_sel_t c, dst_t d,
                                  logic last);
    uop_t u;
    u = '{op: op, src_a: a, src_b: b, coef: c, dst: d, last: last};
    return u;
  endfunction

  // per-axis filter program
  function automatic uop_t ucode(logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      // differenced measurement
      PC_W'(0):  u = mk_uop(OP_SUB,  SRC_M,    SRC_P,    C_A11,  DST_DIFF, 1'b0);
      // rate prediction
      PC_W'(1):  u = mk_uop(OP_LOAD, SRC_R,    SRC_ZERO, C_A11,  DST_NONE, 1'b0);
      PC_W'(2):  u = mk_uop(OP_MAC,  SRC_A,    SRC_ZERO, C_A21,  DST_NONE, 1'b0);
      PC_W'(3):  u = mk_uop(OP_MAC,  SRC_B,    SRC_ZERO, C_A23,  DST_NONE, 1'b0);
      PC_W'(4):  u = mk_uop(OP_MAC,  SRC_U,    SRC_ZERO, C_B21,  DST_R1,   1'b0);
      // acceleration prediction
      PC_W'(5):  u = mk_uop(OP_MUL,  SRC_A,    SRC_ZERO, C_A11,  DST_NONE, 1'b0);
      PC_W'(6):  u = mk_uop(OP_MAC,  SRC_B,    SRC_ZERO, C_A13,  DST_NONE, 1'b0);
      PC_W'(7):  u = mk_uop(OP_MAC,  SRC_U,    SRC_ZERO, C_B11,  DST_A1,   1'b0);
      // innovations
      PC_W'(8):  u = mk_uop(OP_MUL,  SRC_DIFF, SRC_ZERO, C_INVP, DST_NONE, 1'b0);
      PC_W'(9):  u = mk_uop(OP_SUB,  SRC_ACC,  SRC_A1,   C_A11,  DST_EA,   1'b0);
      PC_W'(10): u = mk_uop(OP_SUB,  SRC_M,    SRC_R1,   C_A11,  DST_ER,   1'b0);
      // acceleration correction
      PC_W'(11): u = mk_uop(OP_LOAD, SRC_A1,   SRC_ZERO, C_A11,  DST_NONE, 1'b0);
      PC_W'(12): u = mk_uop(OP_MAC,  SRC_EA,   SRC_ZERO, C_KAA,  DST_NONE, 1'b0);
      PC_W'(13): u = mk_uop(OP_MAC,  SRC_ER,   SRC_ZERO, C_KAR,  DST_A,    1'b0);
      // rate correction
      PC_W'(14): u = mk_uop(OP_LOAD, SRC_R1,   SRC_ZERO, C_A11,  DST_NONE, 1'b0);
      PC_W'(15): u = mk_uop(OP_MAC,  SRC_EA,   SRC_ZERO, C_KRA,  DST_NONE, 1'b0);
      PC_W'(16): u = mk_uop(OP_MAC,  SRC_ER,   SRC_ZERO, C_KRR,  DST_R,    1'b0);
      // bias correction
      PC_W'(17): u = mk_uop(OP_LOAD, SRC_B,    SRC_ZERO, C_A11,  DST_NONE, 1'b0);
      PC_W'(18): u = mk_uop(OP_MAC,  SRC_EA,   SRC_ZERO, C_KBA,  DST_NONE, 1'b0);
      PC_W'(19): u = mk_uop(OP_MAC,  SRC_ER,   SRC_ZERO, C_KBR,  DST_B,    1'b0);
      // keep measurement for next tick
      PC_W'(20): u = mk_uop(OP_LOAD, SRC_M,    SRC_ZERO, C_A11,  DST_P,    1'b1);
      default:   u = mk_uop(OP_LOAD, SRC_ZERO, SRC_ZERO, C_A11,  DST_NONE, 1'b1);
    endcase
    return u;
  endfunction

endpackage

FILE: hdl/tarkf_if.sv
interface tarkf_in_if import tarkf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] roll_accel_command;
  logic signed [FIELD_W-1:0] pitch_accel_command;
  logic signed [FIELD_W-1:0] roll_rate_measured;
  logic signed [FIELD_W-1:0] pitch_rate_measured;

  modport source (
    output valid, roll_accel_command, pitch_accel_command,
    output roll_rate_measured, pitch_rate_measured,
    input  ready
  );
  modport sink (
    input  valid, roll_accel_command, pitch_accel_command,
    input  roll_rate_measured, pitch_rate_measured,
    output ready
  );
endinterface

interface tarkf_out_if import tarkf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] roll_accel_estimate;
  logic signed [FIELD_W-1:0] roll_rate_estimate;
  logic signed [FIELD_W-1:0] pitch_accel_estimate;
  logic signed [FIELD_W-1:0] pitch_rate_estimate;

  modport source (
    output valid, roll_accel_estimate, roll_rate_estimate,
    output pitch_accel_estimate, pitch_rate_estimate,
    input  ready
  );
  modport sink (
    input  valid, roll_accel_estimate, roll_rate_estimate,
    input  pitch_accel_estimate, pitch_rate_estimate,
    output ready
  );
endinterface

FILE: hdl/tarkf_regs.sv
module tarkf_regs import tarkf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:REG_ADDR_LSB]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.arow  <= '0;
      cfg_r.rrow  <= '0;
      cfg_r.incf  <= '0;
      cfg_r.kacc  <= '0;
      cfg_r.krate <= '0;
      cfg_r.kbias <= '0;
      cfg_r.invp  <= INV_PERIOD_RST;
    end else if (wr_en) begin
      case (idx)
        REG_ACCEL_ROW:  cfg_r.arow  <= cfg_pwdata;
        REG_RATE_ROW:   cfg_r.rrow  <= cfg_pwdata;
        REG_INPUT_COEF: cfg_r.incf  <= cfg_pwdata;
        REG_ACCEL_GAIN: cfg_r.kacc  <= cfg_pwdata;
        REG_RATE_GAIN:  cfg_r.krate <= cfg_pwdata;
        REG_BIAS_GAIN:  cfg_r.kbias <= cfg_pwdata;
        REG_INV_PERIOD: cfg_r.invp  <= cfg_pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (idx)
      REG_ACCEL_ROW:  cfg_prdata = cfg_r.arow;
      REG_RATE_ROW:   cfg_prdata = cfg_r.rrow;
      REG_INPUT_COEF: cfg_prdata = cfg_r.incf;
      REG_ACCEL_GAIN: cfg_prdata = cfg_r.kacc;
      REG_RATE_GAIN:  cfg_prdata = cfg_r.krate;
      REG_BIAS_GAIN:  cfg_prdata = cfg_r.kbias;
      REG_INV_PERIOD: cfg_prdata = CFG_DATA_W'(cfg_r.invp);
      default:        cfg_prdata = '0;
    endcase
  end

endmodule

FILE: hdl/tarkf_ctrl.sv
module tarkf_ctrl import tarkf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  state_t          state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            axis_r, axis_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            advance;
  uop_t            uop;

  assign uop       = ucode(pc_r);
  assign out_valid = out_valid_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // sequencing and datapath commands
  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    advance       = 1'b0;
    cmd           = '{capture: 1'b0, publish: 1'b0, axis: axis_r, phase: PH_IDLE, uop: uop};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          pc_nxt      = '0;
          axis_nxt    = 1'b0;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (uop.op == OP_MUL || uop.op == OP_MAC) begin
          cmd.phase = PH_MUL_LO;
          state_nxt = ST_MUL_HI;
        end else begin
          cmd.phase = PH_EXEC;
          advance   = 1'b1;
        end
      end
      ST_MUL_HI: begin
        cmd.phase = PH_MUL_HI;
        state_nxt = ST_MUL_COMB;
      end
      ST_MUL_COMB: begin
        cmd.phase = PH_MUL_COMB;
        state_nxt = ST_MUL_ACC;
      end
      ST_MUL_ACC: begin
        cmd.phase = PH_MUL_ACC;
        advance   = 1'b1;
      end
      ST_DONE: begin
        // hand over once the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // step the program, roll axis then pitch axis
    if (advance) begin
      if (uop.last) begin
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          pc_nxt    = '0;
          state_nxt = ST_EXEC;
        end else begin
          state_nxt = ST_DONE;
        end
      end else begin
        pc_nxt    = pc_r + 1'b1;
        state_nxt = ST_EXEC;
      end
    end
  end

endmodule

FILE: hdl/tarkf_dp.sv
module tarkf_dp import tarkf_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dp_cmd_t                   cmd,
  input  cfg_t                      cfg,
  input  logic signed [FIELD_W-1:0] in_roll_cmd,
  input  logic signed [FIELD_W-1:0] in_pitch_cmd,
  input  logic signed [FIELD_W-1:0] in_roll_meas,
  input  logic signed [FIELD_W-1:0] in_pitch_meas,
  output logic signed [FIELD_W-1:0] out_roll_accel,
  output logic signed [FIELD_W-1:0] out_roll_rate,
  output logic signed [FIELD_W-1:0] out_pitch_accel,
  output logic signed [FIELD_W-1:0] out_pitch_rate
);

  localparam int DW   = DATA_WIDTH;
  localparam int LO_W = DW / 2;
  localparam int HI_W = DW - LO_W;
  localparam int MA_W = COEF_W + 1;
  localparam int MB_W = HI_W + 1;
  localparam int PR_W = MA_W + MB_W;
  localparam int FU_W = MA_W + DW + 1;
  localparam int XW   = (DW > FIELD_W) ? DW : FIELD_W;
  localparam longint DMAX = (64'sd1 <<< (DW - 1)) - 64'sd1;
  localparam longint DMIN = -DMAX - 64'sd1;
  localparam longint FMAX = (64'sd1 <<< (FIELD_W - 1)) - 64'sd1;
  localparam longint FMIN = -FMAX - 64'sd1;

  // per-axis state, index 0 roll, 1 pitch
  logic signed [DW-1:0] st_a_r [2];
  logic signed [DW-1:0] st_r_r [2];
  logic signed [DW-1:0] st_b_r [2];
  logic signed [DW-1:0] st_p_r [2];
  logic signed [DW-1:0] u_r    [2];
  logic signed [DW-1:0] m_r    [2];

  // working registers
  logic signed [DW-1:0]   acc_r, acc_nxt;
  logic signed [DW-1:0]   r1_r, a1_r, diff_r, ea_r, er_r;
  logic signed [DW-1:0]   prod_r, prod_nxt;
  logic signed [PR_W-1:0] lo_r, hi_r;

  logic signed [FIELD_W-1:0] out_ra_r, out_rr_r, out_pa_r, out_pr_r;

  logic                   ax;
  logic                   wr;
  logic signed [DW-1:0]   va, vb;
  logic signed [MA_W-1:0] coef;
  logic                   use_period;
  logic signed [MB_W-1:0] mul_b;
  logic signed [PR_W-1:0] mul_p;
  logic signed [FU_W-1:0] full, shq;

  function automatic logic signed [DW-1:0] sat_sum(logic signed [DW:0] s);
    logic signed [DW-1:0] r;
    if (s[DW] != s[DW-1]) begin
      r = s[DW] ? DW'(DMIN) : DW'(DMAX);
    end else begin
      r = s[DW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DW-1:0] from_field(logic signed [FIELD_W-1:0] v);
    logic signed [XW-1:0] x;
    logic signed [DW-1:0] r;
    x = XW'(v);
    if (x > XW'(DMAX)) begin
      r = DW'(DMAX);
    end else if (x < XW'(DMIN)) begin
      r = DW'(DMIN);
    end else begin
      r = x[DW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [FIELD_W-1:0] to_field(logic signed [DW-1:0] v);
    logic signed [XW-1:0]      x;
    logic signed [FIELD_W-1:0] r;
    x = XW'(v);
    if (x > XW'(FMAX)) begin
      r = FIELD_W'(FMAX);
    end else if (x < XW'(FMIN)) begin
      r = FIELD_W'(FMIN);
    end else begin
      r = x[FIELD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DW-1:0] src_val(src_t s);
    logic signed [DW-1:0] v;
    case (s)
      SRC_ACC:  v = acc_r;
      SRC_A:    v = st_a_r[ax];
      SRC_R:    v = st_r_r[ax];
      SRC_B:    v = st_b_r[ax];
      SRC_P:    v = st_p_r[ax];
      SRC_U:    v = u_r[ax];
      SRC_M:    v = m_r[ax];
      SRC_R1:   v = r1_r;
      SRC_A1:   v = a1_r;
      SRC_DIFF: v = diff_r;
      SRC_EA:   v = ea_r;
      SRC_ER:   v = er_r;
      default:  v = '0;
    endcase
    return v;
  endfunction

  assign ax = cmd.axis;

  // operand select
  always_comb begin
    va = src_val(cmd.uop.src_a);
    vb = src_val(cmd.uop.src_b);
  end

  // coefficient select, Q10.22 words sign extended, period zero extended
  always_comb begin
    use_period = 1'b0;
    case (cmd.uop.coef)
      C_A11:   coef = MA_W'($signed(cfg.arow[63:32]));
      C_A13:   coef = MA_W'($signed(cfg.arow[31:0]));
      C_A21:   coef = MA_W'($signed(cfg.rrow[63:32]));
      C_A23:   coef = MA_W'($signed(cfg.rrow[31:0]));
      C_B11:   coef = MA_W'($signed(cfg.incf[63:32]));
      C_B21:   coef = MA_W'($signed(cfg.incf[31:0]));
      C_KAA:   coef = MA_W'($signed(cfg.kacc[63:32]));
      C_KAR:   coef = MA_W'($signed(cfg.kacc[31:0]));
      C_KRA:   coef = MA_W'($signed(cfg.krate[63:32]));
      C_KRR:   coef = MA_W'($signed(cfg.krate[31:0]));
      C_KBA:   coef = MA_W'($signed(cfg.kbias[63:32]));
      C_KBR:   coef = MA_W'($signed(cfg.kbias[31:0]));
      C_INVP: begin
        coef       = MA_W'({1'b0, cfg.invp});
        use_period = 1'b1;
      end
      default: coef = '0;
    endcase
  end

  // shared multiplier, low half of the operand then high half
  always_comb begin
    if (cmd.phase == PH_MUL_HI) begin
      mul_b = MB_W'($signed(va[DW-1:LO_W]));
    end else begin
      mul_b = MB_W'(va[LO_W-1:0]);
    end
  end

  assign mul_p = coef * mul_b;

  // recombine halves, floor shift, saturate
  always_comb begin
    full = (FU_W'(hi_r) <<< LO_W) + FU_W'(lo_r);
    shq  = use_period ? (full >>> PERIOD_FRAC) : (full >>> COEF_FRAC);
    if (shq > FU_W'(DMAX)) begin
      prod_nxt = DW'(DMAX);
    end else if (shq < FU_W'(DMIN)) begin
      prod_nxt = DW'(DMIN);
    end else begin
      prod_nxt = shq[DW-1:0];
    end
  end

  // accumulator update
  always_comb begin
    acc_nxt = acc_r;
    wr      = 1'b0;
    case (cmd.phase)
      PH_EXEC: begin
        wr = 1'b1;
        case (cmd.uop.op)
          OP_SUB:  acc_nxt = sat_sum((DW + 1)'(va) - (DW + 1)'(vb));
          default: acc_nxt = va;
        endcase
      end
      PH_MUL_ACC: begin
        wr = 1'b1;
        if (cmd.uop.op == OP_MAC) begin
          acc_nxt = sat_sum((DW + 1)'(acc_r) + (DW + 1)'(prod_r));
        end else begin
          acc_nxt = prod_r;
        end
      end
      default: ;
    endcase
  end

  // filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        st_a_r[i] <= '0;
        st_r_r[i] <= '0;
        st_b_r[i] <= '0;
        st_p_r[i] <= '0;
      end
    end else if (wr) begin
      case (cmd.uop.dst)
        DST_A:   st_a_r[ax] <= acc_nxt;
        DST_R:   st_r_r[ax] <= acc_nxt;
        DST_B:   st_b_r[ax] <= acc_nxt;
        DST_P:   st_p_r[ax] <= acc_nxt;
        default: ;
      endcase
    end
  end

  // working registers and scratch values
  always_ff @(posedge clk) begin
    if (wr) begin
      acc_r <= acc_nxt;
      case (cmd.uop.dst)
        DST_R1:   r1_r   <= acc_nxt;
        DST_A1:   a1_r   <= acc_nxt;
        DST_DIFF: diff_r <= acc_nxt;
        DST_EA:   ea_r   <= acc_nxt;
        DST_ER:   er_r   <= acc_nxt;
        default: ;
      endcase
    end
    if (cmd.phase == PH_MUL_LO) begin
      lo_r <= mul_p;
    end
    if (cmd.phase == PH_MUL_HI) begin
      hi_r <= mul_p;
    end
    if (cmd.phase == PH_MUL_COMB) begin
      prod_r <= prod_nxt;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      u_r[0] <= from_field(in_roll_cmd);
      u_r[1] <= from_field(in_pitch_cmd);
      m_r[0] <= from_field(in_roll_meas);
      m_r[1] <= from_field(in_pitch_meas);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_ra_r <= to_field(st_a_r[0]);
      out_rr_r <= to_field(st_r_r[0]);
      out_pa_r <= to_field(st_a_r[1]);
      out_pr_r <= to_field(st_r_r[1]);
    end
  end

  assign out_roll_accel  = out_ra_r;
  assign out_roll_rate   = out_rr_r;
  assign out_pitch_accel = out_pa_r;
  assign out_pitch_rate  = out_pr_r;

endmodule

FILE: hdl/two_axis_rate_kalman_filter_top.sv
// channel   role     handshake        payload
// in_ch     sink     valid / ready    commands and measured rates, 4 x Q16.16
// out_ch    source   valid / ready    acceleration and rate estimates, 4 x Q16.16
// cfg_*     slave    psel / penable   seven coefficient registers, 64-bit data
//
// one transaction runs two passes of a 21-step program through the datapath; 13 steps
// use the single shared multiplier and pass through low half, high half, recombine
// and accumulate in turn, and the other 8 steps execute without the multiplier
// rst_n is synchronous; it clears the filter state and loads register defaults
// the next input is taken once the result sits in the output register; a result
// held by a stalled sink only delays the hand-over of the following one
module two_axis_rate_kalman_filter_top import tarkf_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tarkf_in_if.sink              in_ch,
  tarkf_out_if.source           out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t    cfg;
  dp_cmd_t cmd;

  // configuration registers
  tarkf_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // sequencer
  tarkf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // arithmetic and state
  tarkf_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg             (cfg),
    .in_roll_cmd     (in_ch.roll_accel_command),
    .in_pitch_cmd    (in_ch.pitch_accel_command),
    .in_roll_meas    (in_ch.roll_rate_measured),
    .in_pitch_meas   (in_ch.pitch_rate_measured),
    .out_roll_accel  (out_ch.roll_accel_estimate),
    .out_roll_rate   (out_ch.roll_rate_estimate),
    .out_pitch_accel (out_ch.pitch_accel_estimate),
    .out_pitch_rate  (out_ch.pitch_rate_estimate)
  );

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tarkf_pkg::*;

  localparam int DW            = DEF_DATA_WIDTH;
  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 5;
  localparam int NUM_SETTINGS  = 10;
  localparam int TICKS_PER_SET = 200;
  localparam int DRAIN_CYCLES  = 8;
  localparam int TAIL_CYCLES   = 130;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam int MAX_SHOWN     = 10;

  localparam int ROLL  = 0;
  localparam int PITCH = 1;

  // register index past the end of the map, writes to it must be dropped
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  // Q10.22 one, and stimulus spans in Q16.16
  localparam int COEF_ONE   = 1 << COEF_FRAC;
  localparam int CMD_SPAN   = 4 << 16;
  localparam int WALK_STEP  = 4096;
  localparam int WALK_LIMIT = 20 << 16;
  localparam int NOISE_SPAN = 512;

  localparam logic [FIELD_W-1:0] MAXV = 32'h7FFFFFFF;
  localparam logic [FIELD_W-1:0] MINV = 32'h80000000;

  typedef struct packed {
    logic signed [FIELD_W-1:0] roll_cmd;
    logic signed [FIELD_W-1:0] pitch_cmd;
    logic signed [FIELD_W-1:0] roll_meas;
    logic signed [FIELD_W-1:0] pitch_meas;
  } tick_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] roll_accel;
    logic signed [FIELD_W-1:0] roll_rate;
    logic signed [FIELD_W-1:0] pitch_accel;
    logic signed [FIELD_W-1:0] pitch_rate;
  } tick_out_t;

  typedef enum {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE,
    SINK_PULSE
  } sink_mode_t;

  // filter predictor and queue of estimates still owed by the block
  class estimate_tracker;
    logic [CFG_DATA_W-1:0] arow, rrow, incf, kacc, krate, kbias;
    logic [COEF_W-1:0]     invp;
    longint                acc_st[2], rate_st[2], bias_st[2], last_meas[2];
    tick_out_t             pending_estimates[$];
    int unsigned           failures, compared, ticks_taken;

    function new();
      arow = '0; rrow = '0; incf = '0;
      kacc = '0; krate = '0; kbias = '0;
      invp = INV_PERIOD_RST;
      for (int ax = 0; ax < 2; ax++) begin
        acc_st[ax] = 0; rate_st[ax] = 0; bias_st[ax] = 0; last_meas[ax] = 0;
      end
      failures = 0; compared = 0; ticks_taken = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_ACCEL_ROW:  arow  = value;
        REG_RATE_ROW:   rrow  = value;
        REG_INPUT_COEF: incf  = value;
        REG_ACCEL_GAIN: kacc  = value;
        REG_RATE_GAIN:  krate = value;
        REG_BIAS_GAIN:  kbias = value;
        REG_INV_PERIOD: invp  = value[COEF_W-1:0];
        default: ;
      endcase
    endfunction

    // saturate to the internal datapath width
    function longint clip(logic signed [127:0] v);
      logic signed [127:0] hi, lo;
      hi = (128'sd1 <<< (DW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return longint'(hi);
      if (v < lo) return longint'(lo);
      return longint'(v);
    endfunction

    function longint sadd(longint a, longint b);
      logic signed [127:0] s;
      s = a;
      s = s + b;
      return clip(s);
    endfunction

    // exact product, floor shift, then saturate
    function longint scale(longint c, longint v, int k);
      logic signed [127:0] p;
      p = c;
      p = p * v;
      p = p >>> k;
      return clip(p);
    endfunction

    function longint hi_word(logic [CFG_DATA_W-1:0] r);
      return longint'($signed(r[63:32]));
    endfunction

    function longint lo_word(logic [CFG_DATA_W-1:0] r);
      return longint'($signed(r[31:0]));
    endfunction

    function logic [FIELD_W-1:0] to_out(longint v);
      if (v > 64'sd2147483647) return MAXV;
      if (v < -64'sd2147483648) return MINV;
      return v[FIELD_W-1:0];
    endfunction

    // predict, then correct one axis
    function void step_axis(int ax, longint u, longint m);
      longint r1, a1, diff, dm, ea, er, na, nr, nb;
      r1 = sadd(rate_st[ax], scale(hi_word(rrow), acc_st[ax], COEF_FRAC));
      r1 = sadd(r1, scale(lo_word(rrow), bias_st[ax], COEF_FRAC));
      r1 = sadd(r1, scale(lo_word(incf), u, COEF_FRAC));
      a1 = scale(hi_word(arow), acc_st[ax], COEF_FRAC);
      a1 = sadd(a1, scale(lo_word(arow), bias_st[ax], COEF_FRAC));
      a1 = sadd(a1, scale(hi_word(incf), u, COEF_FRAC));
      // differenced measurement and innovations
      diff = sadd(m, -last_meas[ax]);
      dm = scale(longint'({32'd0, invp}), diff, PERIOD_FRAC);
      ea = sadd(dm, -a1);
      er = sadd(m, -r1);
      na = sadd(sadd(a1, scale(hi_word(kacc), ea, COEF_FRAC)),
                scale(lo_word(kacc), er, COEF_FRAC));
      nr = sadd(sadd(r1, scale(hi_word(krate), ea, COEF_FRAC)),
                scale(lo_word(krate), er, COEF_FRAC));
      nb = sadd(sadd(bias_st[ax], scale(hi_word(kbias), ea, COEF_FRAC)),
                scale(lo_word(kbias), er, COEF_FRAC));
      acc_st[ax]    = na;
      rate_st[ax]   = nr;
      bias_st[ax]   = nb;
      last_meas[ax] = m;
    endfunction

    function void take_tick(tick_in_t t);
      tick_out_t e;
      step_axis(ROLL, clip(t.roll_cmd), clip(t.roll_meas));
      step_axis(PITCH, clip(t.pitch_cmd), clip(t.pitch_meas));
      e.roll_accel  = to_out(acc_st[ROLL]);
      e.roll_rate   = to_out(rate_st[ROLL]);
      e.pitch_accel = to_out(acc_st[PITCH]);
      e.pitch_rate  = to_out(rate_st[PITCH]);
      pending_estimates.push_back(e);
      ticks_taken++;
    endfunction

    function void compare_field(string name, logic [FIELD_W-1:0] want,
                                logic [FIELD_W-1:0] got);
      if (want !== got) begin
        if (failures < MAX_SHOWN)
          $display("mismatch on %s at estimate %0d: expected %0d (%08h), got %0d (%08h)",
                   name, compared, $signed(want), want, $signed(got), got);
        failures++;
      end
    endfunction

    function void match_estimate(tick_out_t got);
      tick_out_t want;
      if (pending_estimates.size() == 0) begin
        if (failures < MAX_SHOWN)
          $display("estimate %08h %08h %08h %08h arrived with no tick pending",
                   got.roll_accel, got.roll_rate, got.pitch_accel, got.pitch_rate);
        failures++;
        return;
      end
      want = pending_estimates.pop_front();
      compare_field("roll_accel_estimate", want.roll_accel, got.roll_accel);
      compare_field("roll_rate_estimate", want.roll_rate, got.roll_rate);
      compare_field("pitch_accel_estimate", want.pitch_accel, got.pitch_accel);
      compare_field("pitch_rate_estimate", want.pitch_rate, got.pitch_rate);
      compared++;
    endfunction

    function int pending_count();
      return pending_estimates.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  tarkf_in_if  tick_in ();
  tarkf_out_if est_out ();

  estimate_tracker tracker = new();

  int unsigned burst_left = 0;
  int unsigned settings_done = 0;
  int unsigned cycles = 0;
  int          rate_walk[2] = '{0, 0};

  two_axis_rate_kalman_filter_top #(.DATA_WIDTH(DW)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (tick_in),
    .out_ch      (est_out),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // clock
  always #(CLK_PERIOD / 2) clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d estimates pending", cycles,
               tracker.pending_count());
      $display("FAIL two_axis_rate_kalman_filter_top");
      $finish;
    end
  end

  // signed value in [-span, span]
  function automatic logic [31:0] rand_span(int span);
    int v;
    v = int'($urandom_range(0, 2 * span)) - span;
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pair(int hi, int lo);
    return {hi, lo};
  endfunction

  function automatic logic [FIELD_W-1:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return MAXV;
      1: return MINV;
      2: return '0;
      3: return '1;
      4: return 32'd1;
      default: return $urandom;
    endcase
  endfunction

  // mostly smooth gyro traces, some noise and rail values
  function automatic tick_in_t random_tick();
    tick_in_t    t;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      for (int ax = 0; ax < 2; ax++) begin
        rate_walk[ax] += int'(rand_span(WALK_STEP));
        if (rate_walk[ax] > WALK_LIMIT) rate_walk[ax] = WALK_LIMIT;
        if (rate_walk[ax] < -WALK_LIMIT) rate_walk[ax] = -WALK_LIMIT;
      end
      t.roll_cmd   = rand_span(CMD_SPAN);
      t.pitch_cmd  = rand_span(CMD_SPAN);
      t.roll_meas  = rate_walk[ROLL] + int'(rand_span(NOISE_SPAN));
      t.pitch_meas = rate_walk[PITCH] + int'(rand_span(NOISE_SPAN));
    end else if (kind < 85) begin
      t = {$urandom, $urandom, $urandom, $urandom};
    end else begin
      t = {pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()};
    end
    return t;
  endfunction

  // apb write: setup, then access until pready
  task automatic write_reg(logic [2:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(idx) << REG_ADDR_LSB;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    tracker.set_reg(idx, value);
  endtask

  // one coefficient setting per phase, the rails among them
  task automatic load_setting(int ph);
    logic [CFG_DATA_W-1:0] coefs [6];
    logic [CFG_DATA_W-1:0] period;
    bit                    write_period;
    write_period = 1'b1;
    period = '0;
    case (ph)
      0: begin
        // a tame filter, period left at its reset value
        coefs = '{pair(3984589, -209715), pair(32768, -16384), pair(419430, 4096),
                  pair(1258291, 838861), pair(20972, 2516582), pair(-419430, 41943)};
        write_period = 1'b0;
      end
      1: begin
        foreach (coefs[i]) coefs[i] = pair(rand_span(COEF_ONE), rand_span(COEF_ONE / 4));
        period = {$urandom, 32'd0};
      end
      2: begin
        foreach (coefs[i]) coefs[i] = pair(MAXV, MAXV);
        period = {$urandom, 32'hFFFFFFFF};
      end
      3: begin
        foreach (coefs[i]) coefs[i] = pair(MINV, MINV);
        period = 64'd1;
      end
      4: begin
        foreach (coefs[i]) coefs[i] = '1;
        period = '1;
      end
      5: begin
        foreach (coefs[i]) coefs[i] = '0;
        period = '0;
      end
      9: begin
        foreach (coefs[i]) coefs[i] = {$urandom, $urandom};
        period = {$urandom, $urandom};
      end
      default: begin
        foreach (coefs[i]) coefs[i] = pair(rand_span(COEF_ONE), rand_span(COEF_ONE / 2));
        period = {$urandom, $urandom_range(1 << 16, 1 << 24)};
      end
    endcase
    for (int i = REG_ACCEL_ROW; i <= REG_BIAS_GAIN; i++) write_reg(3'(i), coefs[i]);
    if (write_period) write_reg(REG_INV_PERIOD, period);
    if (ph == 3) write_reg(REG_UNMAPPED, {$urandom, $urandom});
    settings_done++;
  endtask

  // input transaction, sent in bursts with random gaps
  task automatic send_tick(tick_in_t t);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 4);
      if (gap != 0) begin
        tick_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    tick_in.valid               <= 1'b1;
    tick_in.roll_accel_command  <= t.roll_cmd;
    tick_in.pitch_accel_command <= t.pitch_cmd;
    tick_in.roll_rate_measured  <= t.roll_meas;
    tick_in.pitch_rate_measured <= t.pitch_meas;
    @(posedge clk);
    while (!tick_in.ready) @(posedge clk);
    tracker.take_tick(t);
    burst_left--;
  endtask

  // first tick carries a nonzero rate against the cleared previous sample
  task automatic run_directed();
    send_tick('{32'sd65536, -32'sd65536, 32'sd32768, -32'sd32768});
    send_tick('{32'sd65536, -32'sd65536, 32'sd32768, -32'sd32768});
    send_tick('{'0, '0, '0, '0});
    send_tick('{MAXV, MAXV, MAXV, MAXV});
    send_tick('{MINV, MINV, MINV, MINV});
    send_tick('{MAXV, MAXV, MAXV, MAXV});
    send_tick('{'0, '0, '0, '0});
    send_tick('{MAXV, MINV, MAXV, MINV});
    send_tick('{MINV, MAXV, MINV, MAXV});
    send_tick('{MAXV, MAXV, MINV, MINV});
    send_tick('{MINV, MINV, MAXV, MAXV});
    send_tick('{'1, '1, '1, '1});
    send_tick('{32'd1, 32'd1, 32'd1, 32'd1});
    send_tick('{32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA});
    send_tick('{32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555});
    send_tick('{'0, '0, '0, '0});
    send_tick('{32'sd131072, 32'sd131072, 32'sd6554, -32'sd6554});
  endtask

  // wait until every estimate is back and the block is idle
  task automatic drain();
    tick_in.valid <= 1'b0;
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  // result sink with its own stall pattern, and the result monitor
  initial begin
    sink_mode_t  mode;
    int unsigned mode_left;
    int unsigned pulse_wait;
    tick_out_t   got;
    mode = SINK_OPEN;
    mode_left = 0;
    pulse_wait = 0;
    est_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && est_out.valid && est_out.ready) begin
        got = '{est_out.roll_accel_estimate, est_out.roll_rate_estimate,
                est_out.pitch_accel_estimate, est_out.pitch_rate_estimate};
        tracker.match_estimate(got);
      end
      if (mode_left == 0) begin
        mode = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(100, 3000);
      end
      mode_left--;
      case (mode)
        SINK_OPEN:   est_out.ready <= 1'b1;
        SINK_COIN:   est_out.ready <= 1'($urandom_range(0, 1));
        SINK_SPARSE: est_out.ready <= ($urandom_range(0, 7) == 0);
        default: begin
          if (pulse_wait == 0) begin
            est_out.ready <= 1'b1;
            pulse_wait = $urandom_range(0, 100);
          end else begin
            est_out.ready <= 1'b0;
            pulse_wait--;
          end
        end
      endcase
    end
  end

  // reset, then settings with their stimulus
  initial begin
    rst_n                       <= 1'b0;
    cfg_psel                    <= 1'b0;
    cfg_penable                 <= 1'b0;
    cfg_pwrite                  <= 1'b0;
    cfg_paddr                   <= '0;
    cfg_pwdata                  <= '0;
    tick_in.valid               <= 1'b0;
    tick_in.roll_accel_command  <= '0;
    tick_in.pitch_accel_command <= '0;
    tick_in.roll_rate_measured  <= '0;
    tick_in.pitch_rate_measured <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      load_setting(ph);
      if (ph == 0) run_directed();
      for (int i = 0; i < TICKS_PER_SET; i++) send_tick(random_tick());
      drain();
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d ticks through %0d coefficient settings, rails and zero period included",
             tracker.ticks_taken, settings_done);
    $display("%0d estimates compared, %0d failures, %0d estimates outstanding",
             tracker.compared, tracker.failures, tracker.pending_count());
    if (tracker.failures == 0 && tracker.pending_count() == 0) begin
      $display("PASS two_axis_rate_kalman_filter_top");
    end else begin
      $display("FAIL two_axis_rate_kalman_filter_top");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/tarkf_pkg.sv
hdl/tarkf_if.sv
hdl/tarkf_regs.sv
hdl/tarkf_ctrl.sv
hdl/tarkf_dp.sv
hdl/two_axis_rate_kalman_filter_top.sv
tb/testbench.sv
